[sv/mlpe_pkg.sv]
package mlpe_pkg;

    localparam int PACKET_BYTES = 15;
    localparam int PKT_IDX_W    = $clog2(PACKET_BYTES);

    // input item kinds (s_tuser)
    typedef enum logic [2:0] {
        OP_RX       = 3'd0,
        OP_TICK     = 3'd1,
        OP_SET_MODE = 3'd2,
        OP_RELATIVE = 3'd3,
        OP_PAUSE    = 3'd4,
        OP_RESUME   = 3'd5
    } op_t;

    // result kinds (m_tuser)
    typedef enum logic [1:0] {
        KIND_TX           = 2'd0,
        KIND_READING      = 2'd1,
        KIND_MODE_DONE    = 2'd2,
        KIND_MODE_TIMEOUT = 2'd3
    } kind_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_NODATA     = 3'd0,
        CFG_MODE_CMD   = 3'd1,
        CFG_POLL_INTVL = 3'd2,
        CFG_MODE_TMO   = 3'd3,
        CFG_STEP_DELAY = 3'd4
    } cfg_idx_t;

    localparam logic [7:0] START_BYTE  = 8'hA0;
    localparam logic [7:0] ACK_BYTE    = 8'hDD;
    localparam logic [7:0] POLL_BYTE0  = 8'h01;
    localparam logic [7:0] POLL_BYTE1  = 8'h0F;
    localparam logic [7:0] REL_CODE    = 8'hF3;
    localparam logic [7:0] GROUP_MASK  = 8'hF0;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;

    localparam logic [2:0] PFX_NONE  = 3'd0;
    localparam logic [2:0] PFX_MICRO = 3'd1;
    localparam logic [2:0] PFX_MILLI = 3'd2;
    localparam logic [2:0] PFX_KILO  = 3'd3;
    localparam logic [2:0] PFX_MEGA  = 3'd4;
    localparam logic [2:0] PFX_NANO  = 3'd5;
    localparam logic [2:0] PFX_BEEP  = 3'd6;

    localparam logic [2:0] UNIT_DEGF    = 3'd0;
    localparam logic [2:0] UNIT_DEGC    = 3'd1;
    localparam logic [2:0] UNIT_FARAD   = 3'd2;
    localparam logic [2:0] UNIT_OHM     = 3'd3;
    localparam logic [2:0] UNIT_AMP     = 3'd4;
    localparam logic [2:0] UNIT_VOLT    = 3'd5;
    localparam logic [2:0] UNIT_UNKNOWN = 3'd6;

    typedef struct packed {
        logic        ok;
        logic [13:0] magnitude;
        logic [1:0]  frac_digits;
        logic        negative;
        logic [2:0]  prefix;
        logic [2:0]  unit;
        logic [3:0]  flags;
    } reading_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [13:0] magnitude;
        logic [1:0]  frac_digits;
        logic        negative;
        logic [2:0]  prefix;
        logic [2:0]  unit;
        logic [3:0]  flags;
        logic        last;
    } res_t;

    function automatic res_t make_res(kind_t kind, logic [7:0] tx_byte);
        res_t r;
        r         = '0;
        r.kind    = kind;
        r.tx_byte = tx_byte;
        return r;
    endfunction

endpackage

[sv/mlpe_decode.sv]
module mlpe_decode
    import mlpe_pkg::*;
(
    input  logic [7:0] pkt [PACKET_BYTES],
    output reading_t   rd
);

    logic [3:0]  dig [4];
    logic [3:0]  dig_ok;
    logic [7:0]  dp_byte;
    logic [7:0]  acdc;
    logic [7:0]  mult;
    logic [7:0]  units;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dig_ok[i] = (pkt[2 + i] >= ASCII_ZERO) && (pkt[2 + i] <= ASCII_NINE);
            dig[i]    = pkt[2 + i][3:0];
        end
    end

    assign dp_byte = pkt[7];
    assign acdc    = pkt[8];
    assign mult    = pkt[10];
    assign units   = pkt[11];

    always_comb
    begin
        rd           = '0;
        rd.ok        = &dig_ok;
        rd.magnitude = 14'(dig[0] * 14'd1000) + 14'(dig[1] * 14'd100)
                     + 14'(dig[2] * 14'd10) + 14'(dig[3]);
        rd.negative  = pkt[1][2];

        // decimal point position byte, offset from ASCII zero
        priority if (dp_byte == ASCII_ZERO + 8'd1)
            rd.frac_digits = 2'd3;
        else if (dp_byte >= ASCII_ZERO + 8'd2 && dp_byte <= ASCII_ZERO + 8'd3)
            rd.frac_digits = 2'd2;
        else if (dp_byte >= ASCII_ZERO + 8'd4 && dp_byte <= ASCII_ZERO + 8'd7)
            rd.frac_digits = 2'd1;
        else
            rd.frac_digits = 2'd0;

        priority if (mult == 8'h80)
            rd.prefix = PFX_MICRO;
        else if (mult == 8'h40)
            rd.prefix = PFX_MILLI;
        else if (mult == 8'h20)
            rd.prefix = PFX_KILO;
        else if (mult == 8'h10)
            rd.prefix = PFX_MEGA;
        else if (mult == 8'h08)
            rd.prefix = PFX_BEEP;
        else if (pkt[9][1])
            rd.prefix = PFX_NANO;
        else
            rd.prefix = PFX_NONE;

        priority if (units == 8'h01)
            rd.unit = UNIT_DEGF;
        else if (units == 8'h02)
            rd.unit = UNIT_DEGC;
        else if (units == 8'h04)
            rd.unit = UNIT_FARAD;
        else if (units == 8'h20)
            rd.unit = UNIT_OHM;
        else if (units == 8'h40)
            rd.unit = UNIT_AMP;
        else if (units == 8'h80)
            rd.unit = UNIT_VOLT;
        else
            rd.unit = UNIT_UNKNOWN;

        // relative, auto, DC, AC
        rd.flags = {acdc[2], acdc[5], acdc[4], acdc[3]};
    end

endmodule

[sv/meter_link_protocol_engine.sv]
// Channel   Dir  Transaction                  Payload
// s_*       in   rx byte / tick / command     tuser = mode, tdata = rx_byte, mode_code
// m_*       out  tx byte or event             tuser = kind, tdata = result fields, tlast
// cfg_*     in   register write               cfg_index, cfg_data
//
// An accepted item waits in the input register, then is processed combinationally
// into a two-entry result buffer once the buffer is empty or popping its last result.
// The buffer drains one result per cycle while m_tready is high; poll, relative and
// mode step items give two results. Reset clears all control state but not the
// packet store, which may still hold bytes of earlier packets. m_tready low holds
// the buffer and, once the input register is full, drops s_tready.
module meter_link_protocol_engine
    import mlpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] mode_code
    input  logic [2:0]  s_tuser,   // [2:0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] tx_byte, [21:8] magnitude, [23:22] frac_digits,
                                   // [24] negative, [27:25] prefix, [30:28] unit,
                                   // [34:31] flags, [39:35] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_POLL,
        ST_WAIT,
        ST_MODE,
        ST_DELAY
    } state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] rx_byte;
        logic [7:0] mode_code;
    } in_item_t;

    // configuration
    logic [7:0]  nodata_reg;
    logic [7:0]  mode_cmd_reg;
    logic [15:0] poll_interval_reg;
    logic [15:0] mode_timeout_reg;
    logic [15:0] step_delay_reg;

    // input register
    logic        in_valid_reg;
    in_item_t    in_reg;

    // link state
    state_t                 state_reg,        state_next;
    logic [PKT_IDX_W-1:0]   byte_count_reg,   byte_count_next;
    logic [7:0]             target_reg,       target_next;
    logic [3:0]             sub_step_reg,     sub_step_next;
    logic                   poll_running_reg, poll_running_next;
    logic [15:0]            poll_ticks_reg,   poll_ticks_next;
    logic [15:0]            stage_ticks_reg,  stage_ticks_next;

    logic [7:0]  store_reg [PACKET_BYTES];
    logic        store_we;
    logic [7:0]  pkt_view [PACKET_BYTES];
    reading_t    rd;

    // result buffer
    res_t        res_reg [2];
    logic [1:0]  res_cnt_reg;
    res_t        res_new [2];
    logic [1:0]  res_k;

    logic        proc_fire;
    logic        pop;
    logic        pkt_final;
    logic [15:0] poll_inc;
    logic [15:0] stage_inc;
    logic [7:0]  step_code;

    function automatic logic [7:0] cur_code(logic [7:0] target, logic [3:0] sub);
        if ((target & GROUP_MASK) == GROUP_MASK)
            return target;
        else
            return {target[7:4], sub};
    endfunction

    assign cfg_ready = 1'b1;
    assign pop       = m_tvalid && m_tready;
    assign proc_fire = in_valid_reg
                    && ((res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && m_tready));
    assign s_tready  = !in_valid_reg || proc_fire;

    assign m_tvalid = (res_cnt_reg != 2'd0);
    assign m_tuser  = res_reg[0].kind;
    assign m_tlast  = res_reg[0].last;
    assign m_tdata  = {5'd0, res_reg[0].flags, res_reg[0].unit, res_reg[0].prefix,
                       res_reg[0].negative, res_reg[0].frac_digits,
                       res_reg[0].magnitude, res_reg[0].tx_byte};

    assign poll_inc  = (poll_ticks_reg == 16'hFFFF) ? poll_ticks_reg : poll_ticks_reg + 16'd1;
    assign stage_inc = (stage_ticks_reg == 16'hFFFF) ? stage_ticks_reg : stage_ticks_reg + 16'd1;
    assign step_code = cur_code(target_reg, sub_step_reg);
    assign pkt_final = (byte_count_reg == PKT_IDX_W'(PACKET_BYTES - 1));

    // current byte merged over the store so the last byte decodes in the same cycle
    always_comb
    begin
        for (int i = 0; i < PACKET_BYTES; i++)
            pkt_view[i] = (byte_count_reg == PKT_IDX_W'(i)) ? in_reg.rx_byte : store_reg[i];
    end

    mlpe_decode u_decode (
        .pkt (pkt_view),
        .rd  (rd)
    );

    always_comb
    begin
        state_next        = state_reg;
        byte_count_next   = byte_count_reg;
        target_next       = target_reg;
        sub_step_next     = sub_step_reg;
        poll_running_next = poll_running_reg;
        poll_ticks_next   = poll_ticks_reg;
        stage_ticks_next  = stage_ticks_reg;
        store_we          = 1'b0;
        res_new[0]        = '0;
        res_new[1]        = '0;
        res_k             = 2'd0;

        if (proc_fire)
        begin
            unique case (op_t'(in_reg.mode))
                OP_RX:
                begin
                    if (state_reg == ST_MODE)
                    begin
                        if (in_reg.rx_byte == ACK_BYTE)
                        begin
                            stage_ticks_next = '0;
                            if (step_code == target_reg)
                            begin
                                state_next        = ST_POLL;
                                poll_running_next = 1'b1;
                                poll_ticks_next   = '0;
                                res_new[res_k[0]] = make_res(KIND_MODE_DONE, 8'd0);
                                res_k             = res_k + 2'd1;
                            end
                            else
                            begin
                                sub_step_next = sub_step_reg + 4'd1;
                                state_next    = ST_DELAY;
                            end
                        end
                    end
                    else if (state_reg != ST_DELAY)
                    begin
                        if (byte_count_reg == '0)
                        begin
                            priority if (in_reg.rx_byte == nodata_reg)
                                state_next = ST_POLL;
                            else if (in_reg.rx_byte == START_BYTE)
                            begin
                                store_we        = 1'b1;
                                byte_count_next = PKT_IDX_W'(1);
                            end
                            else
                                state_next = state_reg;
                        end
                        else
                        begin
                            store_we = 1'b1;
                            if (pkt_final)
                            begin
                                byte_count_next = '0;
                                state_next      = ST_POLL;
                                if (rd.ok)
                                begin
                                    res_new[res_k[0]]             = make_res(KIND_READING, 8'd0);
                                    res_new[res_k[0]].magnitude   = rd.magnitude;
                                    res_new[res_k[0]].frac_digits = rd.frac_digits;
                                    res_new[res_k[0]].negative    = rd.negative;
                                    res_new[res_k[0]].prefix      = rd.prefix;
                                    res_new[res_k[0]].unit        = rd.unit;
                                    res_new[res_k[0]].flags       = rd.flags;
                                    res_k                         = res_k + 2'd1;
                                end
                            end
                            else
                                byte_count_next = byte_count_reg + PKT_IDX_W'(1);
                        end
                    end
                end
                OP_TICK:
                begin
                    priority if (poll_running_reg
                                 && (state_reg == ST_POLL || state_reg == ST_WAIT))
                    begin
                        poll_ticks_next = poll_inc;
                        if (poll_inc >= poll_interval_reg)
                        begin
                            poll_ticks_next = '0;
                            if (state_reg == ST_WAIT)
                                byte_count_next = '0;
                            state_next = ST_WAIT;
                            res_new[0] = make_res(KIND_TX, POLL_BYTE0);
                            res_new[1] = make_res(KIND_TX, POLL_BYTE1);
                            res_k      = 2'd2;
                        end
                    end
                    else if (state_reg == ST_MODE)
                    begin
                        stage_ticks_next = stage_inc;
                        if (stage_inc >= mode_timeout_reg)
                        begin
                            stage_ticks_next  = '0;
                            state_next        = ST_POLL;
                            poll_running_next = 1'b1;
                            poll_ticks_next   = '0;
                            res_new[0]        = make_res(KIND_MODE_TIMEOUT, 8'd0);
                            res_k             = 2'd1;
                        end
                    end
                    else if (state_reg == ST_DELAY)
                    begin
                        stage_ticks_next = stage_inc;
                        if (stage_inc >= step_delay_reg)
                        begin
                            stage_ticks_next = '0;
                            state_next       = ST_MODE;
                            res_new[0]       = make_res(KIND_TX, mode_cmd_reg);
                            res_new[1]       = make_res(KIND_TX, step_code);
                            res_k            = 2'd2;
                        end
                    end
                    else
                        state_next = state_reg;
                end
                OP_SET_MODE:
                begin
                    if (state_reg == ST_POLL || state_reg == ST_WAIT)
                    begin
                        poll_running_next = 1'b0;
                        byte_count_next   = '0;
                        sub_step_next     = '0;
                        target_next       = in_reg.mode_code;
                        stage_ticks_next  = '0;
                        state_next        = ST_MODE;
                        res_new[0]        = make_res(KIND_TX, mode_cmd_reg);
                        res_new[1]        = make_res(KIND_TX, cur_code(in_reg.mode_code, 4'd0));
                        res_k             = 2'd2;
                    end
                end
                OP_RELATIVE:
                begin
                    if (state_reg == ST_POLL)
                    begin
                        res_new[0] = make_res(KIND_TX, mode_cmd_reg);
                        res_new[1] = make_res(KIND_TX, REL_CODE);
                        res_k      = 2'd2;
                    end
                end
                OP_PAUSE:
                begin
                    poll_running_next = 1'b0;
                    byte_count_next   = '0;
                    stage_ticks_next  = '0;
                    state_next        = ST_POLL;
                end
                OP_RESUME:
                begin
                    stage_ticks_next  = '0;
                    state_next        = ST_POLL;
                    poll_running_next = 1'b1;
                    poll_ticks_next   = '0;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase

            if (res_k != 2'd0)
                res_new[1'(res_k - 2'd1)].last = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[byte_count_reg] <= in_reg.rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodata_reg        <= 8'd0;
            mode_cmd_reg      <= 8'd0;
            poll_interval_reg <= 16'd200;
            mode_timeout_reg  <= 16'd500;
            step_delay_reg    <= 16'd50;
            in_valid_reg      <= 1'b0;
            in_reg            <= '0;
            state_reg         <= ST_POLL;
            byte_count_reg    <= '0;
            target_reg        <= '0;
            sub_step_reg      <= '0;
            poll_running_reg  <= 1'b1;
            poll_ticks_reg    <= '0;
            stage_ticks_reg   <= '0;
            res_reg[0]        <= '0;
            res_reg[1]        <= '0;
            res_cnt_reg       <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_NODATA:     nodata_reg        <= cfg_data[7:0];
                    CFG_MODE_CMD:   mode_cmd_reg      <= cfg_data[7:0];
                    CFG_POLL_INTVL: poll_interval_reg <= cfg_data;
                    CFG_MODE_TMO:   mode_timeout_reg  <= cfg_data;
                    CFG_STEP_DELAY: step_delay_reg    <= cfg_data;
                    default:        nodata_reg        <= nodata_reg;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                in_valid_reg     <= 1'b1;
                in_reg.mode      <= s_tuser;
                in_reg.rx_byte   <= s_tdata[7:0];
                in_reg.mode_code <= s_tdata[15:8];
            end
            else if (proc_fire)
                in_valid_reg <= 1'b0;

            state_reg        <= state_next;
            byte_count_reg   <= byte_count_next;
            target_reg       <= target_next;
            sub_step_reg     <= sub_step_next;
            poll_running_reg <= poll_running_next;
            poll_ticks_reg   <= poll_ticks_next;
            stage_ticks_reg  <= stage_ticks_next;

            // processing only starts once the buffer is drained this cycle
            if (proc_fire)
            begin
                res_reg[0]  <= res_new[0];
                res_reg[1]  <= res_new[1];
                res_cnt_reg <= res_k;
            end
            else if (pop)
            begin
                res_reg[0]  <= res_reg[1];
                res_cnt_reg <= res_cnt_reg - 2'd1;
            end
        end
    end

    a_res_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_proc_drained: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |-> (res_cnt_reg == 2'd0 || (res_cnt_reg == 2'd1 && m_tready)))
        else $error("item processed over undelivered results");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg == 2'd2 |-> !res_reg[0].last)
        else $error("first of two results marked last");

    a_packet_in_poll: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg != '0 |-> (state_reg == ST_POLL || state_reg == ST_WAIT))
        else $error("partial packet held during a mode change");

    a_poll_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        poll_running_reg |-> (state_reg == ST_POLL || state_reg == ST_WAIT))
        else $error("poll timer running during a mode change");

endmodule

[tb/sv/meter_link_protocol_engine_test.sv]
module meter_link_protocol_engine_test;
    import mlpe_pkg::*;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int unsigned RUN_LIMIT_CYCLES = 400000;

    typedef enum logic [1:0] {
        LINK_POLL  = 2'd0,
        LINK_WAIT  = 2'd1,
        LINK_MODE  = 2'd2,
        LINK_DELAY = 2'd3
    } link_state_t;

    typedef struct {
        logic [2:0] op;
        logic [7:0] rx;
        logic [7:0] code;
    } link_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [7:0] rx_byte, [15:8] mode_code
    logic [2:0]  s_tuser = '0;     // [2:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    meter_link_protocol_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    // ---------------------------------------------------------------
    // Link predictor: host-side state, registers and pending results
    // ---------------------------------------------------------------
    link_state_t lk_state;
    logic [7:0]  pkt_bytes [0:15];
    int unsigned pkt_fill;
    logic [7:0]  target;
    logic [3:0]  sub_range;
    bit          poll_on;
    int unsigned poll_cnt;
    int unsigned stage_cnt;

    logic [7:0]  r_nodata;
    logic [7:0]  r_cmd;
    logic [15:0] r_poll;
    logic [15:0] r_tmo;
    logic [15:0] r_step;

    res_t item_results[$];
    res_t due_link_results[$];
    int   fail_count = 0;

    function automatic void reset_link_model();
        lk_state  = LINK_POLL;
        pkt_fill  = 0;
        target    = '0;
        sub_range = '0;
        poll_on   = 1'b1;
        poll_cnt  = 0;
        stage_cnt = 0;
        r_nodata  = 8'h00;
        r_cmd     = 8'h00;
        r_poll    = 16'd200;
        r_tmo     = 16'd500;
        r_step    = 16'd50;
    endfunction

    function automatic void apply_reg(cfg_idx_t idx, logic [15:0] val);
        case (idx)
            CFG_NODATA:     r_nodata = val[7:0];
            CFG_MODE_CMD:   r_cmd    = val[7:0];
            CFG_POLL_INTVL: r_poll   = val;
            CFG_MODE_TMO:   r_tmo    = val;
            CFG_STEP_DELAY: r_step   = val;
            default: ;
        endcase
    endfunction

    function automatic void add_result(kind_t kind, logic [7:0] b);
        res_t r;
        r         = '0;
        r.kind    = kind;
        r.tx_byte = b;
        item_results.push_back(r);
    endfunction

    // codes with group 0xF are sent whole; others step the low nibble
    function automatic logic [7:0] range_code();
        if (target[7:4] == 4'hF)
            return target;
        return {target[7:4], sub_range};
    endfunction

    function automatic void issue_sub_range();
        add_result(KIND_TX, r_cmd);
        add_result(KIND_TX, range_code());
        stage_cnt = 0;
        lk_state  = LINK_MODE;
    endfunction

    function automatic void decode_packet();
        res_t        r;
        int unsigned mag;
        int          d;
        logic [7:0]  c;
        logic [7:0]  acdc;
        mag = 0;
        for (int i = 2; i < 6; i++)
        begin
            c = pkt_bytes[i];
            if (c < ASCII_ZERO || c > ASCII_NINE)
                return;
            mag = mag * 10 + (c - ASCII_ZERO);
        end
        r = '0;
        r.kind = KIND_READING;
        r.magnitude = mag[13:0];
        d = int'(pkt_bytes[7]) - 48;
        if (d == 1)
            r.frac_digits = 2'd3;
        else if (d >= 2 && d <= 3)
            r.frac_digits = 2'd2;
        else if (d >= 4 && d <= 7)
            r.frac_digits = 2'd1;
        else
            r.frac_digits = 2'd0;
        r.negative = pkt_bytes[1][2];
        case (pkt_bytes[10])
            8'h80:   r.prefix = PFX_MICRO;
            8'h40:   r.prefix = PFX_MILLI;
            8'h20:   r.prefix = PFX_KILO;
            8'h10:   r.prefix = PFX_MEGA;
            8'h08:   r.prefix = PFX_BEEP;
            default: r.prefix = pkt_bytes[9][1] ? PFX_NANO : PFX_NONE;
        endcase
        case (pkt_bytes[11])
            8'h01:   r.unit = UNIT_DEGF;
            8'h02:   r.unit = UNIT_DEGC;
            8'h04:   r.unit = UNIT_FARAD;
            8'h20:   r.unit = UNIT_OHM;
            8'h40:   r.unit = UNIT_AMP;
            8'h80:   r.unit = UNIT_VOLT;
            default: r.unit = UNIT_UNKNOWN;
        endcase
        acdc = pkt_bytes[8];
        r.flags = {acdc[2], acdc[5], acdc[4], acdc[3]};
        item_results.push_back(r);
    endfunction

    function automatic void take_byte(logic [7:0] b);
        if (lk_state == LINK_MODE)
        begin
            if (b == ACK_BYTE)
            begin
                stage_cnt = 0;
                if (target[7:4] == 4'hF || range_code() == target)
                begin
                    lk_state = LINK_POLL;
                    poll_on  = 1'b1;
                    poll_cnt = 0;
                    add_result(KIND_MODE_DONE, 8'h00);
                end
                else
                begin
                    sub_range = sub_range + 4'd1;
                    lk_state  = LINK_DELAY;
                end
            end
            return;
        end
        if (lk_state == LINK_DELAY)
            return;
        if (pkt_fill == 0)
        begin
            // no-data byte takes precedence over the start byte
            if (b == r_nodata)
                lk_state = LINK_POLL;
            else if (b == START_BYTE)
            begin
                pkt_bytes[0] = b;
                pkt_fill = 1;
            end
            return;
        end
        if (pkt_fill < PACKET_BYTES)
            pkt_bytes[pkt_fill] = b;
        pkt_fill++;
        if (pkt_fill >= PACKET_BYTES)
        begin
            pkt_fill = 0;
            lk_state = LINK_POLL;
            decode_packet();
        end
    endfunction

    function automatic void take_tick();
        if (poll_on && (lk_state == LINK_POLL || lk_state == LINK_WAIT))
        begin
            if (poll_cnt < 32'hFFFF)
                poll_cnt++;
            if (poll_cnt >= r_poll)
            begin
                poll_cnt = 0;
                // unanswered poll: drop it along with any partial packet
                if (lk_state == LINK_WAIT)
                    pkt_fill = 0;
                add_result(KIND_TX, POLL_BYTE0);
                add_result(KIND_TX, POLL_BYTE1);
                lk_state = LINK_WAIT;
            end
        end
        else if (lk_state == LINK_MODE)
        begin
            if (stage_cnt < 32'hFFFF)
                stage_cnt++;
            if (stage_cnt >= r_tmo)
            begin
                stage_cnt = 0;
                lk_state  = LINK_POLL;
                poll_on   = 1'b1;
                poll_cnt  = 0;
                add_result(KIND_MODE_TIMEOUT, 8'h00);
            end
        end
        else if (lk_state == LINK_DELAY)
        begin
            if (stage_cnt < 32'hFFFF)
                stage_cnt++;
            if (stage_cnt >= r_step)
                issue_sub_range();
        end
    endfunction

    function automatic void predict_link_item(link_item_t item);
        item_results.delete();
        case (item.op)
            OP_RX:   take_byte(item.rx);
            OP_TICK: take_tick();
            OP_SET_MODE:
            begin
                if (lk_state == LINK_POLL || lk_state == LINK_WAIT)
                begin
                    poll_on   = 1'b0;
                    pkt_fill  = 0;
                    sub_range = '0;
                    target    = item.code;
                    issue_sub_range();
                end
            end
            OP_RELATIVE:
            begin
                if (lk_state == LINK_POLL)
                begin
                    add_result(KIND_TX, r_cmd);
                    add_result(KIND_TX, REL_CODE);
                end
            end
            OP_PAUSE:
            begin
                poll_on   = 1'b0;
                pkt_fill  = 0;
                stage_cnt = 0;
                lk_state  = LINK_POLL;
            end
            OP_RESUME:
            begin
                stage_cnt = 0;
                lk_state  = LINK_POLL;
                poll_on   = 1'b1;
                poll_cnt  = 0;
            end
            default: ;
        endcase
        if (item_results.size() > 0)
            item_results[item_results.size() - 1].last = 1'b1;
        foreach (item_results[i])
            due_link_results.push_back(item_results[i]);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus queue and generators
    // ---------------------------------------------------------------
    link_item_t  link_items[$];
    link_item_t  bus_item;
    int unsigned stim_count = 0;
    int          gen_step;
    int          gen_tmo;

    function automatic void queue_item(logic [2:0] op, logic [7:0] b, logic [7:0] code);
        link_item_t it;
        it.op   = op;
        it.rx   = b;
        it.code = code;
        link_items.push_back(it);
        if (op <= OP_RESUME)
            stim_count++;
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        queue_item(OP_RX, b, 8'($urandom));
    endfunction

    function automatic void queue_cmd(logic [2:0] op, logic [7:0] code);
        queue_item(op, 8'($urandom), code);
    endfunction

    function automatic void queue_ticks(int n);
        repeat (n)
            queue_cmd(OP_TICK, 8'($urandom));
    endfunction

    function automatic void queue_reading_packet();
        logic [7:0] pkt [0:PACKET_BYTES-1];
        int         len;
        int         poke;
        int         pick;
        foreach (pkt[i])
            pkt[i] = 8'($urandom);
        pkt[0] = START_BYTE;
        pick = $urandom_range(0, 9);
        for (int i = 2; i < 6; i++)
        begin
            if (pick == 0)
                pkt[i] = ASCII_ZERO;
            else if (pick == 1)
                pkt[i] = ASCII_NINE;
            else
                pkt[i] = ASCII_ZERO + 8'($urandom_range(0, 9));
        end
        if ($urandom_range(0, 7) == 0)
            pkt[$urandom_range(2, 5)] = 8'($urandom);
        if ($urandom_range(0, 4) != 0)
            pkt[7] = ASCII_ZERO + 8'($urandom_range(0, 15));
        case ($urandom_range(0, 6))
            0: pkt[10] = 8'h80;
            1: pkt[10] = 8'h40;
            2: pkt[10] = 8'h20;
            3: pkt[10] = 8'h10;
            4: pkt[10] = 8'h08;
            5: pkt[10] = 8'h00;
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0: pkt[11] = 8'h01;
            1: pkt[11] = 8'h02;
            2: pkt[11] = 8'h04;
            3: pkt[11] = 8'h20;
            4: pkt[11] = 8'h40;
            5: pkt[11] = 8'h80;
            default: ;
        endcase
        len = PACKET_BYTES;
        if ($urandom_range(0, 99) < 15)
            len = $urandom_range(1, PACKET_BYTES - 1);
        poke = ($urandom_range(0, 9) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
        for (int i = 0; i < len; i++)
        begin
            if (i == poke)
                queue_ticks(1);
            queue_byte(pkt[i]);
        end
        if (len < PACKET_BYTES)
        begin
            case ($urandom_range(0, 2))
                0: queue_ticks($urandom_range(1, 8));
                1: queue_cmd(OP_PAUSE, 8'($urandom));
                default: ;
            endcase
        end
    endfunction

    function automatic void queue_mode_change();
        logic [7:0] code;
        int         pick;
        code = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            code[7:4] = 4'hF;
        else if ($urandom_range(0, 1) == 0)
            code[3:0] = 4'($urandom_range(0, 3));
        queue_cmd(OP_SET_MODE, code);
        repeat ($urandom_range(1, 6))
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                queue_byte(ACK_BYTE);
                queue_ticks($urandom_range(0, gen_step + 1));
            end
            else if (pick < 8)
                queue_byte(8'($urandom));
            else
                queue_ticks($urandom_range(1, gen_tmo + 1));
        end
    endfunction

    function automatic void queue_random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            queue_reading_packet();
        else if (pick < 55)
            queue_ticks($urandom_range(1, 6));
        else if (pick < 65)
            queue_byte(r_nodata);
        else if (pick < 80)
            queue_mode_change();
        else if (pick < 88)
            queue_cmd(OP_RELATIVE, 8'($urandom));
        else if (pick < 92)
            queue_cmd(OP_PAUSE, 8'($urandom));
        else if (pick < 96)
            queue_cmd(OP_RESUME, 8'($urandom));
        else if (pick < 98)
            queue_item($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7,
                       8'($urandom), 8'($urandom));
        else
            queue_byte(8'($urandom));
    endfunction

    // ---------------------------------------------------------------
    // Idle pattern shared by both stream sides
    // ---------------------------------------------------------------
    function automatic int next_gap(inout int calm);
        int pick;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    int send_gap  = 0;
    int send_calm = 0;
    int hold_gap  = 0;
    int hold_calm = 0;

    // Input stream driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_link_item(bus_item);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (link_items.size() > 0)
                begin
                    bus_item = link_items.pop_front();
                    s_tdata  <= {bus_item.code, bus_item.rx};
                    s_tuser  <= bus_item.op;
                    s_tvalid <= 1'b1;
                    send_gap = next_gap(send_calm);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_link_result();
        res_t want;
        if (due_link_results.size() == 0)
        begin
            $error("unexpected transaction: kind %0h data %0h", m_tuser, m_tdata);
            fail_count++;
            return;
        end
        want = due_link_results.pop_front();
        compare_field("kind",        want.kind,        m_tuser);
        compare_field("tx_byte",     want.tx_byte,     m_tdata[7:0]);
        compare_field("magnitude",   want.magnitude,   m_tdata[21:8]);
        compare_field("frac_digits", want.frac_digits, m_tdata[23:22]);
        compare_field("negative",    want.negative,    m_tdata[24]);
        compare_field("prefix",      want.prefix,      m_tdata[27:25]);
        compare_field("unit",        want.unit,        m_tdata[30:28]);
        compare_field("flags",       want.flags,       m_tdata[34:31]);
        compare_field("pad",         '0,               m_tdata[39:35]);
        compare_field("last",        want.last,        m_tlast);
    endfunction

    // Output stream monitor; stalls after some transactions
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_link_result();
                hold_gap = next_gap(hold_calm);
            end
            if (hold_gap > 0)
            begin
                hold_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Phase control
    // ---------------------------------------------------------------
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        while (quiet < 8)
        begin
            @(posedge clk);
            if (link_items.size() == 0 && !s_tvalid && due_link_results.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_link_regs(logic [7:0] nodata, logic [7:0] cmd, logic [15:0] poll,
                                 logic [15:0] tmo, logic [15:0] step);
        wait_drained();
        write_reg(CFG_NODATA, {8'h00, nodata});
        write_reg(CFG_MODE_CMD, {8'h00, cmd});
        write_reg(CFG_POLL_INTVL, poll);
        write_reg(CFG_MODE_TMO, tmo);
        write_reg(CFG_STEP_DELAY, step);
        gen_step = (step > 6) ? 6 : step;
        gen_tmo  = (tmo > 12) ? 12 : tmo;
    endtask

    task automatic run_random_phase(logic [7:0] nodata, logic [7:0] cmd, logic [15:0] poll,
                                    logic [15:0] tmo, logic [15:0] step, int budget);
        int unsigned goal;
        set_link_regs(nodata, cmd, poll, tmo, step);
        goal = stim_count + budget;
        while (stim_count < goal)
            queue_random_burst();
    endtask

    initial
    begin
        reset_link_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: each command, ignored cases, a full stepped mode change
        set_link_regs(8'h5A, 8'hC3, 16'd2, 16'd3, 16'd1);
        queue_item(OP_SPARE6, 8'hFF, 8'hFF);
        queue_item(OP_SPARE7, 8'h00, 8'h00);
        queue_ticks(2);
        queue_cmd(OP_RELATIVE, 8'h00);      // waiting for reply: ignored
        queue_byte(8'h5A);
        queue_cmd(OP_RELATIVE, 8'hFF);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_cmd(OP_SET_MODE, 8'h12);
        queue_byte(ACK_BYTE);
        queue_byte(ACK_BYTE);               // during step delay: discarded
        queue_ticks(1);
        queue_cmd(OP_SET_MODE, 8'hFF);      // already changing: ignored
        queue_byte(8'h33);
        queue_byte(ACK_BYTE);
        queue_ticks(1);
        queue_byte(ACK_BYTE);
        queue_cmd(OP_SET_MODE, 8'hFF);
        queue_ticks(3);
        queue_cmd(OP_SET_MODE, 8'h00);
        queue_cmd(OP_PAUSE, 8'h00);
        queue_ticks(1);
        queue_cmd(OP_RESUME, 8'h00);

        run_random_phase(8'($urandom), 8'($urandom), 16'($urandom_range(2, 8)),
                         16'($urandom_range(2, 10)), 16'($urandom_range(1, 4)), 200);
        run_random_phase(8'h00, 8'h00, 16'd1, 16'd1, 16'd1, 80);
        run_random_phase(START_BYTE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 40);
        // zero timer values behave as one
        run_random_phase(8'hFF, 8'h80, 16'd0, 16'd0, 16'd0, 60);
        run_random_phase(8'($urandom), 8'($urandom), 16'($urandom_range(3, 16)),
                         16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)), 200);
        run_random_phase(8'($urandom), 8'($urandom), 16'($urandom_range(1, 5)),
                         16'($urandom_range(2, 6)), 16'($urandom_range(1, 3)), 70);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("meter_link_protocol_engine_test OK");
        else
            $display("meter_link_protocol_engine_test NOT OK");
        $finish;
    end

    initial
    begin
        #(64'(RUN_LIMIT_CYCLES) * 20);
        $display("meter_link_protocol_engine_test NOT OK");
        $finish;
    end

endmodule
